// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/fasd_pkg.sv =====
// ----------------------------------------------------------------------------
// fasd_pkg
// types and constants of the flight arming state detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fasd_pkg;

   typedef enum logic [2:0] {
      ST_DISARMED   = 3'd0,
      ST_ARMED      = 3'd1,
      ST_READY      = 3'd2,
      ST_TAKING_OFF = 3'd3,
      ST_FLYING     = 3'd4,
      ST_LANDING    = 3'd5,
      ST_TESTING    = 3'd6
   } state_type;

   // pilot commands
   localparam logic [7:0] CMD_DISARM = 8'd0;
   localparam logic [7:0] CMD_ARM    = 8'd1;
   localparam logic [7:0] CMD_LAND   = 8'd2;

   // register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_TOUCHDOWN_RANGE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LANDING_HOLD_TICKS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TILT_LIMIT         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LANDING_MIN_RANGE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TAKEOFF_RANGE      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_THROTTLE_START     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_STICK_EXTREME      = 3'd6;

   // register reset values
   localparam logic [15:0]        RST_TOUCHDOWN_RANGE    = 16'd10;
   localparam logic [6:0]         RST_LANDING_HOLD_TICKS = 7'd50;
   localparam logic [11:0]        RST_TILT_LIMIT         = 12'd960;
   localparam logic [15:0]        RST_LANDING_MIN_RANGE  = 16'd500;
   localparam logic [15:0]        RST_TAKEOFF_RANGE      = 16'd100;
   localparam logic signed [11:0] RST_THROTTLE_START     = 12'sd80;
   localparam logic [10:0]        RST_STICK_EXTREME      = 11'd1440;
   localparam logic [7:0]         RST_LANDING_COUNTDOWN  = 8'd50;

   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned REQ_BITS   = 99;
   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned RSP_DATA_W = 8;

endpackage

// ===== rtl/flight_arming_state_detector_core.sv =====
// ----------------------------------------------------------------------------
// flight_arming_state_detector_core
// per-tick arming and flight state tracker for a multirotor controller
// ----------------------------------------------------------------------------
// each request is one control tick: pilot command, four stick positions,
// downward range, measured roll and pitch and a calibration pass pulse.
// each request gives exactly one response holding the new flight state and
// a flag that is set when the state differs from that of the previous tick.
// a request is taken into an input register, goes through the combinational
// state checks and lands in a response register: rsp_tvalid rises as it moves
// there; while rsp_tready stays high, one request is taken every cycle.
// the state, last command, calibration latch and landing countdown are
// updated as the request moves to the response register, so back-to-back
// ticks see the state left by the one before.
// when the receiver stalls, the response register holds and the input
// register fills; req_tready drops only once both are full.
// reset (synchronous) empties both registers, restores the registers of
// the csr port to their defaults and returns to disarmed, uncalibrated.
// the csr port must be written while no request is in flight; not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module flight_arming_state_detector_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // request tdata, from bit 0: pilot_command[8], stick_roll[12], stick_pitch[12],
   // stick_yaw[12], stick_throttle[12], ground_range[16], attitude_roll[13],
   // attitude_pitch[13], calibration_passed[1], zero pad[5]
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [fasd_pkg::REQ_DATA_W-1:0]        req_tdata,
   // response tdata, from bit 0: flight_state[3], state_changed[1], zero pad[4]
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [fasd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  logic                                   csr_we,
   input  logic [fasd_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [fasd_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // configuration registers
   logic [15:0]        touchdown_range_ff;
   logic [6:0]         landing_hold_ticks_ff;
   logic [11:0]        tilt_limit_ff;
   logic [15:0]        landing_min_range_ff;
   logic [15:0]        takeoff_range_ff;
   logic signed [11:0] throttle_start_ff;
   logic [10:0]        stick_extreme_ff;

   // tick state
   fasd_pkg::state_type state_ff, state_in;
   logic [7:0]          prev_cmd_ff;
   logic                imu_ready_ff, imu_ready_in;
   logic [7:0]          countdown_ff, countdown_in;

   // pipeline registers
   logic                             in_valid_ff;
   logic [fasd_pkg::REQ_BITS-1:0]    in_data_ff;
   logic                             out_valid_ff;
   logic [2:0]                       out_state_ff;
   logic                             out_changed_ff;

   logic advance;

   // unpacked request fields
   logic [7:0]         cmd;
   logic signed [11:0] s_roll, s_pitch, s_yaw, s_thr;
   logic [15:0]        range;
   logic signed [12:0] a_roll, a_pitch;
   logic               cal_pass;

   logic signed [12:0] ext_pos, ext_neg;
   logic [12:0]        abs_roll, abs_pitch;
   logic               on_ground, gesture, thr_low, tilted;

   assign cmd      = in_data_ff[7:0];
   assign s_roll   = signed'(in_data_ff[19:8]);
   assign s_pitch  = signed'(in_data_ff[31:20]);
   assign s_yaw    = signed'(in_data_ff[43:32]);
   assign s_thr    = signed'(in_data_ff[55:44]);
   assign range    = in_data_ff[71:56];
   assign a_roll   = signed'(in_data_ff[84:72]);
   assign a_pitch  = signed'(in_data_ff[97:85]);
   assign cal_pass = in_data_ff[98];

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_changed_ff, out_state_ff};

   assign ext_pos = signed'({2'b00, stick_extreme_ff});
   assign ext_neg = -ext_pos;

   // magnitude of the most negative angle still fits as unsigned
   assign abs_roll  = a_roll[12]  ? (~a_roll + 13'd1)  : a_roll;
   assign abs_pitch = a_pitch[12] ? (~a_pitch + 13'd1) : a_pitch;

   assign on_ground = range < touchdown_range_ff;
   assign thr_low   = 13'(s_thr) == ext_neg;
   assign gesture   = (13'(s_yaw) == ext_neg) && thr_low
                      && (13'(s_roll) == ext_pos) && (13'(s_pitch) == ext_neg);
   assign tilted    = (abs_roll > {1'b0, tilt_limit_ff})
                      || (abs_pitch > {1'b0, tilt_limit_ff});

   // checks run in order; one tick may step through several states
   always_comb begin
      state_in     = state_ff;
      countdown_in = countdown_ff;
      imu_ready_in = imu_ready_ff || cal_pass;

      if (cmd == fasd_pkg::CMD_DISARM) begin
         state_in = fasd_pkg::ST_DISARMED;
      end
      if (cmd == fasd_pkg::CMD_ARM && prev_cmd_ff == fasd_pkg::CMD_DISARM && imu_ready_in) begin
         state_in = fasd_pkg::ST_ARMED;
      end
      if (state_in == fasd_pkg::ST_ARMED && gesture) begin
         state_in = fasd_pkg::ST_READY;
      end
      if (state_in == fasd_pkg::ST_READY && s_thr > throttle_start_ff) begin
         state_in = (cmd == fasd_pkg::CMD_ARM) ? fasd_pkg::ST_TAKING_OFF
                                               : fasd_pkg::ST_TESTING;
      end
      if (state_in == fasd_pkg::ST_TAKING_OFF && range > takeoff_range_ff) begin
         state_in = fasd_pkg::ST_FLYING;
      end
      if (state_in == fasd_pkg::ST_FLYING) begin
         if (on_ground && thr_low) begin
            state_in = fasd_pkg::ST_DISARMED;
         end else if (cmd == fasd_pkg::CMD_LAND && prev_cmd_ff != fasd_pkg::CMD_LAND
                      && range > landing_min_range_ff) begin
            state_in = fasd_pkg::ST_LANDING;
         end
      end
      if ((state_in == fasd_pkg::ST_TAKING_OFF || state_in == fasd_pkg::ST_FLYING)
          && tilted) begin
         state_in = fasd_pkg::ST_DISARMED;
      end
      if (state_in == fasd_pkg::ST_LANDING) begin
         if (on_ground) begin
            if (countdown_ff == 8'd0) begin
               state_in = fasd_pkg::ST_DISARMED;
            end else begin
               countdown_in = countdown_ff - 8'd1;
            end
         end else begin
            countdown_in = {1'b0, landing_hold_ticks_ff};
         end
         // leaving the land command overrides a touchdown disarm
         if (cmd != fasd_pkg::CMD_LAND) begin
            state_in = fasd_pkg::ST_FLYING;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touchdown_range_ff    <= fasd_pkg::RST_TOUCHDOWN_RANGE;
         landing_hold_ticks_ff <= fasd_pkg::RST_LANDING_HOLD_TICKS;
         tilt_limit_ff         <= fasd_pkg::RST_TILT_LIMIT;
         landing_min_range_ff  <= fasd_pkg::RST_LANDING_MIN_RANGE;
         takeoff_range_ff      <= fasd_pkg::RST_TAKEOFF_RANGE;
         throttle_start_ff     <= fasd_pkg::RST_THROTTLE_START;
         stick_extreme_ff      <= fasd_pkg::RST_STICK_EXTREME;
      end else if (csr_we) begin
         unique case (csr_index)
            fasd_pkg::REG_TOUCHDOWN_RANGE:    touchdown_range_ff    <= csr_wdata;
            fasd_pkg::REG_LANDING_HOLD_TICKS: landing_hold_ticks_ff <= csr_wdata[6:0];
            fasd_pkg::REG_TILT_LIMIT:         tilt_limit_ff         <= csr_wdata[11:0];
            fasd_pkg::REG_LANDING_MIN_RANGE:  landing_min_range_ff  <= csr_wdata;
            fasd_pkg::REG_TAKEOFF_RANGE:      takeoff_range_ff      <= csr_wdata;
            fasd_pkg::REG_THROTTLE_START:     throttle_start_ff     <= signed'(csr_wdata[11:0]);
            fasd_pkg::REG_STICK_EXTREME:      stick_extreme_ff      <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fasd_pkg::ST_DISARMED;
         prev_cmd_ff  <= fasd_pkg::CMD_DISARM;
         imu_ready_ff <= 1'b0;
         countdown_ff <= fasd_pkg::RST_LANDING_COUNTDOWN;
      end else if (advance) begin
         state_ff     <= state_in;
         prev_cmd_ff  <= cmd;
         imu_ready_ff <= imu_ready_in;
         countdown_ff <= countdown_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata[fasd_pkg::REQ_BITS-1:0];
      end
      if (advance) begin
         out_state_ff   <= state_in;
         out_changed_ff <= state_in != state_ff;
      end
   end

   `ASSERT_NEXT(a_changed_vs_prior, clock, reset, !reset && advance,
      rsp_tdata[3] == (rsp_tdata[2:0] != $past(state_ff)))
   `ASSERT_NEXT(a_state_holds_idle, clock, reset, !reset && !advance, $stable(state_ff))
   `ASSERT_NEXT(a_imu_latch_sticks, clock, reset, !reset && imu_ready_ff, imu_ready_ff)
   `ASSERT_IMPLY(a_no_drop_on_stall, clock, reset, in_valid_ff && out_valid_ff && !rsp_tready,
      !req_tready)

endmodule
